/* hdl/rlce_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rlce_pkg;

    localparam int DIV_STEPS  = 16;
    localparam int PIXEL_BITS = 24;

    localparam logic [8:0] PIXEL_COUNT_RESET = 9'd8;
    localparam logic [7:0] CODE_ONE_RESET    = 8'd248;
    localparam logic [7:0] CODE_ZERO_RESET   = 8'd192;

    typedef enum logic [1:0] {
        CFG_PIXEL_COUNT = 2'd0,
        CFG_CODE_ONE    = 2'd1,
        CFG_CODE_ZERO   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic       use_wheel;
        logic [7:0] pixel_index;
        logic [9:0] frame_offset;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last;
    } code_out_t;

    // One slot of the divider chain: remaining dividend bits, partial
    // remainder, low quotient bits, and the pixel riding along.
    typedef struct packed {
        logic [15:0] num;
        logic [8:0]  rem;
        logic [7:0]  quo;
        pixel_in_t   pix;
    } div_stage_t;

    // Color wheel: returns {green, red, blue} for a wheel position.
    function automatic logic [23:0] wheel_color(input logic [7:0] pos);
        logic [7:0] w;
        logic [7:0] t;
        logic [9:0] tri3;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        w = ~pos;
        if (w < 8'd85) begin
            t = w;
        end else if (w < 8'd170) begin
            t = w - 8'd85;
        end else begin
            t = w - 8'd170;
        end
        tri3 = {2'b00, t} + {1'b0, t, 1'b0};
        if (w < 8'd85) begin
            r = 8'd255 - tri3[7:0];
            g = 8'd0;
            b = tri3[7:0];
        end else if (w < 8'd170) begin
            r = 8'd0;
            g = tri3[7:0];
            b = 8'd255 - tri3[7:0];
        end else begin
            r = tri3[7:0];
            g = 8'd255 - tri3[7:0];
            b = 8'd0;
        end
        return {g, r, b};
    endfunction

endpackage

`default_nettype wire

/* hdl/rlce_div_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module rlce_div_cell
    import rlce_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       valid_in,
    input  wire div_stage_t stage_in,
    input  wire logic [8:0] divisor,
    output logic            valid_out,
    output div_stage_t      stage_out
);

    logic       valid_reg;
    div_stage_t stage_reg;
    div_stage_t stage_next;
    logic [9:0] trial;
    logic [9:0] diff;

    // One restoring division step: bring down the next dividend bit.
    always_comb
    begin
        trial = {stage_in.rem, stage_in.num[15]};
        diff  = trial - {1'b0, divisor};
        stage_next     = stage_in;
        stage_next.num = {stage_in.num[14:0], 1'b0};
        if (trial >= {1'b0, divisor}) begin
            stage_next.rem = diff[8:0];
            stage_next.quo = {stage_in.quo[6:0], 1'b1};
        end else begin
            stage_next.rem = trial[8:0];
            stage_next.quo = {stage_in.quo[6:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign valid_out = valid_reg;
    assign stage_out = stage_reg;

endmodule

`default_nettype wire

/* hdl/rlce_serializer.sv */
`timescale 1ns / 1ps
`default_nettype none

module rlce_serializer
    import rlce_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire logic [23:0] word,
    input  wire logic [7:0]  code_one,
    input  wire logic [7:0]  code_zero,
    output logic             free,
    output logic             strobe,
    output code_out_t        code
);

    localparam logic [4:0] LAST_BIT = 5'(PIXEL_BITS - 1);

    logic        active_reg;
    logic        active_next;
    logic [4:0]  cnt_reg;
    logic [4:0]  cnt_next;
    logic [23:0] word_reg;
    logic [23:0] word_next;

    assign free = !active_reg || (cnt_reg == LAST_BIT);

    always_comb
    begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        word_next   = word_reg;
        if (load && free) begin
            active_next = 1'b1;
            cnt_next    = 5'd0;
            word_next   = word;
        end else if (active_reg) begin
            if (cnt_reg == LAST_BIT) begin
                active_next = 1'b0;
            end else begin
                cnt_next  = cnt_reg + 5'd1;
                word_next = {word_reg[22:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            active_reg <= 1'b0;
            cnt_reg    <= 5'd0;
        end else begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign strobe         = active_reg;
    assign code.code_byte = word_reg[23] ? code_one : code_zero;
    assign code.last      = (cnt_reg == LAST_BIT);

endmodule

`default_nettype wire

/* hdl/rainbow_led_code_encoder.sv */
`timescale 1ns / 1ps
`default_nettype none

// Rainbow LED code encoder: one pixel in, 24 SPI code bytes out.
//
// Input: a pixel transaction is accepted at a rising edge where start is
// high and busy is low. Output: each code byte sits on code for exactly one
// cycle with strobe high; the receiver cannot stall, so bytes leave at one
// per cycle, green first, most significant bit first, last set on the 24th.
// Configuration: cfg_valid/cfg_ready write channel; cfg_ready is always high.
// Index 0 is pixel_count, 1 is code_one, 2 is code_zero; other indexes are
// ignored. Write configuration only while the block is idle.
//
// Path: an accepted pixel passes the 16-cell divider chain, then the hold
// register, then the 24-byte serializer, which takes it once it is free. The
// next pixel is taken while the previous one is still being shifted out.
// Pixels whose index is at or above MAX_PIXELS are accepted and dropped.
// Reset clears all control state and restores the configuration defaults.
module rainbow_led_code_encoder
    import rlce_pkg::*;
#(
    parameter int MAX_PIXELS = 256
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire pixel_in_t  pixel,
    output logic            strobe,
    output code_out_t       code,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [8:0] cfg_data
);

    logic [8:0] pixel_count_reg;
    logic [7:0] code_one_reg;
    logic [7:0] code_zero_reg;

    // Register file. Writes to unlisted indexes fall through the default arm.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pixel_count_reg <= PIXEL_COUNT_RESET;
            code_one_reg    <= CODE_ONE_RESET;
            code_zero_reg   <= CODE_ZERO_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_PIXEL_COUNT: pixel_count_reg <= cfg_data;
                CFG_CODE_ONE:    code_one_reg    <= cfg_data[7:0];
                CFG_CODE_ZERO:   code_zero_reg   <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    // A pixel count of zero divides as one.
    logic [8:0] divisor;
    assign divisor = (pixel_count_reg == 9'd0) ? 9'd1 : pixel_count_reg;

    // At most one pixel is in flight between acceptance and the serializer.
    logic pending_reg;
    logic accept;
    logic drop;
    logic take;

    assign busy   = pending_reg;
    assign accept = start && !busy;
    assign drop   = 32'(pixel.pixel_index) >= MAX_PIXELS;

    // Divider chain: each cell performs one restoring step of
    // pixel_index*256 / pixel_count and passes the pixel along.
    logic       chain_valid [DIV_STEPS+1];
    div_stage_t chain_stage [DIV_STEPS+1];

    always_comb
    begin
        chain_valid[0]     = accept && !drop;
        chain_stage[0].num = {pixel.pixel_index, 8'd0};
        chain_stage[0].rem = 9'd0;
        chain_stage[0].quo = 8'd0;
        chain_stage[0].pix = pixel;
    end

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        rlce_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (chain_valid[i]),
            .stage_in  (chain_stage[i]),
            .divisor   (divisor),
            .valid_out (chain_valid[i+1]),
            .stage_out (chain_stage[i+1])
        );
    end

    // Color selection at the end of the chain, held until the serializer is free.
    div_stage_t  tail;
    logic [7:0]  wheel_pos;
    logic [23:0] color_word;
    logic        hold_valid_reg;
    logic        hold_valid_next;
    logic [23:0] hold_word_reg;
    logic        ser_free;

    assign tail      = chain_stage[DIV_STEPS];
    assign wheel_pos = tail.quo + tail.pix.frame_offset[7:0];

    always_comb
    begin
        if (tail.pix.use_wheel) begin
            color_word = wheel_color(wheel_pos);
        end else begin
            color_word = {tail.pix.green, tail.pix.red, tail.pix.blue};
        end
    end

    assign take = hold_valid_reg && ser_free;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (chain_valid[DIV_STEPS]) begin
            hold_valid_next = 1'b1;
        end else if (take) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_valid_reg <= 1'b0;
            pending_reg    <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            if (accept && !drop) begin
                pending_reg <= 1'b1;
            end else if (take) begin
                pending_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (chain_valid[DIV_STEPS]) begin
            hold_word_reg <= color_word;
        end
    end

    rlce_serializer u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (hold_valid_reg),
        .word      (hold_word_reg),
        .code_one  (code_one_reg),
        .code_zero (code_zero_reg),
        .free      (ser_free),
        .strobe    (strobe),
        .code      (code)
    );

endmodule

`default_nettype wire
